FILE: rtl/sis_pkg.sv
`default_nettype none

package sis_pkg;

    localparam int CAPACITY = 16;
    localparam int ID_WIDTH = 32;
    localparam int IN_ID_W  = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int STAT_W   = 3;

    typedef logic [ID_WIDTH-1:0] t_id;
    typedef logic [CNT_W-1:0]    t_count;

    typedef enum logic {
        REQ_ADD    = 1'b0,
        REQ_REMOVE = 1'b1
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_ABSENT   = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_APPLY = 1'b1
    } t_state;

    // control broadcast to every cell
    typedef struct packed {
        logic cmp;
        logic ins;
        logic rem;
    } t_cell_ctl;

    // data handed from a cell to its upper neighbor
    typedef struct packed {
        t_id  entry;
        logic gt;
        logic hit;
    } t_link;

endpackage

`default_nettype wire

FILE: rtl/sis_cell.sv
`default_nettype none

module sis_cell (
    input  wire logic              i_clk,
    input  wire sis_pkg::t_cell_ctl i_ctl,
    input  wire logic              i_valid,
    input  wire sis_pkg::t_id      i_key,
    input  wire sis_pkg::t_link    i_lo,
    input  wire sis_pkg::t_id      i_hi_entry,
    output sis_pkg::t_link         o_link
);

    sis_pkg::t_id r_entry;
    logic         r_eq;
    logic         r_gt;

    // compare phase: empty slots count as larger than any key
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_eq <= i_valid && (r_entry == i_key);
            r_gt <= !i_valid || (r_entry > i_key);
        end
    end

    // apply phase: shift up on insert, shift down on remove
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (i_lo.gt) begin
                r_entry <= i_lo.entry;
            end else if (r_gt) begin
                r_entry <= i_key;
            end
        end else if (i_ctl.rem) begin
            if (i_lo.hit || r_eq) begin
                r_entry <= i_hi_entry;
            end
        end
    end

    assign o_link.entry = r_entry;
    assign o_link.gt    = r_gt;
    assign o_link.hit   = i_lo.hit || r_eq;

endmodule

`default_nettype wire

FILE: rtl/sorted_id_set.sv
`default_nettype none
// sorted set of unique identifiers, held in ascending order in a row of cells
//
// request channel: i_req_type and i_item_id are taken at a rising edge with
// start high and busy low. add (0) inserts the identifier at its sorted place
// unless present or the set is full; remove (1) deletes it if present.
// result channel: o_valid is high for one cycle with o_status and
// o_set_count (count after the request). the receiver cannot stall.
// timing: a request is compared in every cell at once as it is taken, the
// shift is applied at the end of the apply state and the result is registered
// at that same edge. busy is high for the one apply cycle, so no new request
// is taken while one is applied; the compare/apply pair in each cell sets this.
// reset: synchronous active-low i_rst_n empties the set (count zero) and
// clears busy and o_valid; the cell contents are not cleared and are never
// read before being written.
module sorted_id_set (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         i_req_type,
    input  wire logic [sis_pkg::IN_ID_W-1:0]  i_item_id,
    output logic                              o_valid,
    output logic [sis_pkg::STAT_W-1:0]        o_status,
    output logic [sis_pkg::CNT_W-1:0]         o_set_count
);

    sis_pkg::t_state    r_state;
    sis_pkg::t_state    n_state;
    sis_pkg::t_id       r_key;
    sis_pkg::t_req      r_type;
    sis_pkg::t_count    r_count;
    sis_pkg::t_count    n_count;
    logic               r_valid;
    sis_pkg::t_status   r_status;
    sis_pkg::t_status   n_status;
    sis_pkg::t_cell_ctl w_ctl;
    sis_pkg::t_id       w_key;
    logic               w_take;
    logic               w_apply;
    logic               w_present;
    logic               w_full;
    sis_pkg::t_link     w_link [sis_pkg::CAPACITY];

    // next state
    always_comb begin
        case (r_state)
            sis_pkg::S_IDLE:  n_state = start ? sis_pkg::S_APPLY : sis_pkg::S_IDLE;
            sis_pkg::S_APPLY: n_state = sis_pkg::S_IDLE;
            default:          n_state = sis_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        case (r_state)
            sis_pkg::S_IDLE: begin
                busy    = 1'b0;
                w_take  = start;
                w_apply = 1'b0;
            end
            sis_pkg::S_APPLY: begin
                busy    = 1'b1;
                w_take  = 1'b0;
                w_apply = 1'b1;
            end
            default: begin
                busy    = 1'b0;
                w_take  = 1'b0;
                w_apply = 1'b0;
            end
        endcase
    end

    assign w_key     = w_apply ? r_key : sis_pkg::t_id'(i_item_id);
    assign w_present = w_link[sis_pkg::CAPACITY-1].hit;
    assign w_full    = (r_count == sis_pkg::CNT_W'(sis_pkg::CAPACITY));

    assign w_ctl.cmp = w_take;
    assign w_ctl.ins = w_apply && (r_type == sis_pkg::REQ_ADD) && !w_present && !w_full;
    assign w_ctl.rem = w_apply && (r_type == sis_pkg::REQ_REMOVE) && w_present;

    always_comb begin
        n_count = r_count;
        if (r_type == sis_pkg::REQ_ADD) begin
            if (w_present) begin
                n_status = sis_pkg::ST_PRESENT;
            end else if (w_full) begin
                n_status = sis_pkg::ST_FULL;
            end else begin
                n_status = sis_pkg::ST_INSERTED;
                n_count  = r_count + sis_pkg::CNT_W'(1);
            end
        end else begin
            if (w_present) begin
                n_status = sis_pkg::ST_REMOVED;
                n_count  = r_count - sis_pkg::CNT_W'(1);
            end else begin
                n_status = sis_pkg::ST_ABSENT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sis_pkg::S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= w_apply;
            if (w_apply) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_key  <= sis_pkg::t_id'(i_item_id);
            r_type <= sis_pkg::t_req'(i_req_type);
        end
        if (w_apply) begin
            r_status <= n_status;
        end
    end

    for (genvar g = 0; g < sis_pkg::CAPACITY; g++) begin : g_cell
        sis_pkg::t_link w_lo;
        sis_pkg::t_id   w_hi;

        if (g == 0) begin : g_first
            assign w_lo = '0;
        end else begin : g_mid
            assign w_lo = w_link[g-1];
        end

        if (g == sis_pkg::CAPACITY - 1) begin : g_last
            assign w_hi = w_link[g].entry;
        end else begin : g_inner
            assign w_hi = w_link[g+1].entry;
        end

        sis_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_valid    (sis_pkg::CNT_W'(g) < r_count),
            .i_key      (w_key),
            .i_lo       (w_lo),
            .i_hi_entry (w_hi),
            .o_link     (w_link[g])
        );
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_set_count = r_count;

endmodule

`default_nettype wire

FILE: rtl/sis_checker.sv
`default_nettype none

module sis_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic                         o_valid,
    input wire logic [sis_pkg::STAT_W-1:0]   o_status,
    input wire logic [sis_pkg::CNT_W-1:0]    o_set_count
);

    // an accepted request makes the block busy for exactly one cycle
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request");

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held more than one cycle");

    // every accepted request gets its result once its apply state has ended
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("missing result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without request");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_set_count <= sis_pkg::CNT_W'(sis_pkg::CAPACITY))
            && (o_status <= sis_pkg::ST_FULL))
        else $error("result out of range");

endmodule

bind sorted_id_set sis_checker u_sis_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_status    (o_status),
    .o_set_count (o_set_count)
);

`default_nettype wire

FILE: tb/sorted_id_set_tb.sv
`timescale 1ns / 100ps

module sorted_id_set_tb;

    typedef struct {
        sis_pkg::t_req                kind;
        logic [sis_pkg::IN_ID_W-1:0]  id;
    } t_request;

    typedef struct {
        sis_pkg::t_status  status;
        sis_pkg::t_count   count;
    } t_reply;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         start       = 1'b0;
    logic                         i_req_type  = 1'b0;
    logic [sis_pkg::IN_ID_W-1:0]  i_item_id   = '0;
    logic                         busy;
    logic                         o_valid;
    logic [sis_pkg::STAT_W-1:0]   o_status;
    logic [sis_pkg::CNT_W-1:0]    o_set_count;

    t_request      request_queue[$];
    t_reply        pending_replies[$];
    sis_pkg::t_id  shadow_ids[sis_pkg::CAPACITY];
    int            shadow_count = 0;
    int            request_total = 0;
    int            accepted = 0;
    int            mismatches = 0;

    sorted_id_set dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req_type  (i_req_type),
        .i_item_id   (i_item_id),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_set_count (o_set_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic void queue_request(sis_pkg::t_req kind,
                                          logic [sis_pkg::IN_ID_W-1:0] id);
        t_request r;
        r.kind = kind;
        r.id   = id;
        request_queue.push_back(r);
    endfunction

    // applies one request to the shadow copy of the set and returns its reply
    task automatic apply_to_shadow_set(input sis_pkg::t_req kind, input sis_pkg::t_id key,
                                       output t_reply r);
        int pos;
        int k;
        pos = shadow_count;
        for (k = 0; k < shadow_count; k++) begin
            if (shadow_ids[k] == key && pos == shadow_count)
                pos = k;
        end
        if (kind == sis_pkg::REQ_ADD) begin
            if (pos < shadow_count) begin
                r.status = sis_pkg::ST_PRESENT;
            end else if (shadow_count >= sis_pkg::CAPACITY) begin
                r.status = sis_pkg::ST_FULL;
            end else begin
                k = shadow_count;
                while (k > 0 && shadow_ids[k-1] > key) begin
                    shadow_ids[k] = shadow_ids[k-1];
                    k--;
                end
                shadow_ids[k] = key;
                shadow_count++;
                r.status = sis_pkg::ST_INSERTED;
            end
        end else begin
            if (pos >= shadow_count) begin
                r.status = sis_pkg::ST_ABSENT;
            end else begin
                for (k = pos; k < shadow_count - 1; k++)
                    shadow_ids[k] = shadow_ids[k+1];
                shadow_count--;
                r.status = sis_pkg::ST_REMOVED;
            end
        end
        r.count = sis_pkg::t_count'(shadow_count);
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatches < 10)
            $display("%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // request driver
    always @(posedge i_clk) begin
        t_reply  reply;
        int      idle_pct;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_to_shadow_set(sis_pkg::t_req'(i_req_type), sis_pkg::t_id'(i_item_id),
                                    reply);
                pending_replies.push_back(reply);
                accepted++;
            end
            if (!start || !busy) begin
                if (accepted < request_total / 3)
                    idle_pct = 16;
                else if (accepted < 2 * request_total / 3)
                    idle_pct = 64;
                else
                    idle_pct = 0;
                if (request_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    start      <= 1'b1;
                    i_req_type <= request_queue[0].kind;
                    i_item_id  <= request_queue[0].id;
                    void'(request_queue.pop_front());
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_reply  want;
        if (i_rst_n && o_valid) begin
            if (pending_replies.size() == 0) begin
                report_mismatch($sformatf("unexpected result status=%0d count=%0d",
                                          o_status, o_set_count));
            end else begin
                want = pending_replies.pop_front();
                if (o_status !== want.status || o_set_count !== want.count)
                    report_mismatch($sformatf(
                        "mismatch: expected status=%0d count=%0d, got status=%0d count=%0d",
                        want.status, want.count, o_status, o_set_count));
            end
        end
    end

    initial begin
        sis_pkg::t_id   id_pool[24];
        int             add_pct;
        int             guard;
        sis_pkg::t_req  kind;
        logic [sis_pkg::IN_ID_W-1:0] id;

        // directed: empty, extremes, duplicates, fill to full, removals
        queue_request(sis_pkg::REQ_REMOVE, 32'h0000_0005);
        queue_request(sis_pkg::REQ_ADD,    32'h0000_0000);
        queue_request(sis_pkg::REQ_ADD,    32'hFFFF_FFFF);
        queue_request(sis_pkg::REQ_ADD,    32'h0000_0000);
        queue_request(sis_pkg::REQ_REMOVE, 32'h0000_0123);
        for (int k = 14; k >= 1; k--)
            queue_request(sis_pkg::REQ_ADD, k * 32'h1234_5677);
        queue_request(sis_pkg::REQ_ADD,    32'h7777_7777);
        queue_request(sis_pkg::REQ_ADD,    32'hFFFF_FFFF);
        queue_request(sis_pkg::REQ_REMOVE, 32'hFFFF_FFFF);
        queue_request(sis_pkg::REQ_REMOVE, 32'h0000_0000);
        queue_request(sis_pkg::REQ_REMOVE, 7 * 32'h1234_5677);
        queue_request(sis_pkg::REQ_REMOVE, 32'h7777_7777);

        // random: ids mostly from a small pool so hits, fills and misses all occur
        foreach (id_pool[k])
            id_pool[k] = $urandom();
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int n = 0; n < 1200; n++) begin
            if (n % 100 == 0)
                add_pct = $urandom_range(80, 20);
            kind = ($urandom_range(99) < add_pct) ? sis_pkg::REQ_ADD : sis_pkg::REQ_REMOVE;
            if ($urandom_range(9) == 0)
                id = $urandom();
            else
                id = id_pool[$urandom_range(23)];
            queue_request(kind, id);
        end
        request_total = request_queue.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (accepted == request_total);
        guard = 0;
        while (pending_replies.size() != 0 && guard < 1000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_replies.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_replies.size()));

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
